FILE: sv/hslm_pkg.sv
// Shared types and constants of the heading sector lift map.
package hslm_pkg;

  localparam int SECTOR_COUNT = 36;
  localparam int SEC_W        = 6;
  localparam int HEAD_W       = 12;
  localparam int LIFT_W       = 16;
  localparam int SUM_W        = 22;
  localparam int MAG_W        = 21;

  localparam logic [HEAD_W-1:0] FULL_TURN          = 12'd3600;
  localparam logic [HEAD_W-1:0] HALF_TURN          = 12'd1800;
  localparam logic [HEAD_W-1:0] QUARTER_TURN       = 12'd900;
  localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = 12'd2700;
  localparam logic [HEAD_W-1:0] SECTOR_WIDTH       = 12'd100;
  localparam logic [HEAD_W-1:0] HALF_SECTOR        = 12'd50;
  localparam logic [SEC_W-1:0]  LAST_SECTOR        = 6'd35;
  localparam logic [SEC_W-1:0]  SECTOR_TOTAL       = 6'd36;

  // x / 100 == (x * RECIP_100) >> 22, exact for x < 4096
  localparam logic [15:0] RECIP_100       = 16'd41944;
  localparam int          RECIP_100_SHIFT = 22;
  // x / 36 == (x * RECIP_36) >> 27, exact for x < 2**21
  localparam logic [21:0] RECIP_36        = 22'd3728271;
  localparam int          RECIP_36_SHIFT  = 27;

  typedef struct packed {
    logic [HEAD_W-1:0]        heading;
    logic [HEAD_W-1:0]        h_start;
    logic [SEC_W-1:0]         sec_start;
    logic signed [LIFT_W-1:0] climb_rate;
    logic                     turning_left;
    logic                     clear;
    logic                     north;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_SUM,
    ST_SCALE,
    ST_EMIT
  } back_state_t;

endpackage

FILE: sv/hslm_if.sv
// Request and result channel interfaces of the heading sector lift map.
interface hslm_in_if;
  logic                valid;
  logic                ready;
  logic [11:0]         heading;
  logic signed [15:0]  climb_rate;
  logic                circling;
  logic                turning_left;

  modport source(output valid, output heading, output climb_rate, output circling,
                 output turning_left, input ready);
  modport sink(input valid, input heading, input climb_rate, input circling,
               input turning_left, output ready);
endinterface

interface hslm_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  average_lift;

  modport source(output valid, output average_lift, input ready);
  modport sink(input valid, input average_lift, output ready);
endinterface

FILE: sv/hslm_front.sv
// Front end: takes requests, reduces heading, classifies and queues commands.
module hslm_front
  import hslm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  hslm_in_if.sink       in_chan,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic [HEAD_W-1:0] prev_heading_r, prev_heading_nxt;
  logic              prev_circling_r, prev_circling_nxt;

  logic [HEAD_W-1:0] heading_red;
  logic [HEAD_W:0]   start_sum;
  logic [HEAD_W-1:0] start_off;
  logic [27:0]       sec_prod;
  logic              north;

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  always_comb begin
    heading_red = (in_chan.heading >= FULL_TURN) ? in_chan.heading - FULL_TURN
                                                 : in_chan.heading;

    // sector of the previous heading: ((h + 50) mod 3600) / 100
    start_sum = {1'b0, prev_heading_r} + {1'b0, HALF_SECTOR};
    if (start_sum >= {1'b0, FULL_TURN}) begin
      start_off = HEAD_W'(start_sum - {1'b0, FULL_TURN});
    end else begin
      start_off = start_sum[HEAD_W-1:0];
    end
    sec_prod = 28'(start_off) * 28'(RECIP_100);

    north = (heading_red < QUARTER_TURN && prev_heading_r > THREE_QUARTER_TURN) ||
            (prev_heading_r < QUARTER_TURN && heading_red > THREE_QUARTER_TURN);

    q_cmd.heading      = heading_red;
    q_cmd.h_start      = prev_heading_r;
    q_cmd.sec_start    = sec_prod[RECIP_100_SHIFT +: SEC_W];
    q_cmd.climb_rate   = in_chan.climb_rate;
    q_cmd.turning_left = in_chan.turning_left;
    q_cmd.clear        = !in_chan.circling && prev_circling_r;
    q_cmd.north        = north;

    prev_heading_nxt  = prev_heading_r;
    prev_circling_nxt = prev_circling_r;
    if (q_push) begin
      prev_heading_nxt  = heading_red;
      prev_circling_nxt = in_chan.circling;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_heading_r  <= '0;
      prev_circling_r <= 1'b0;
    end else begin
      prev_heading_r  <= prev_heading_nxt;
      prev_circling_r <= prev_circling_nxt;
    end
  end

endmodule

FILE: sv/hslm_queue.sv
// Command queue between front end and back end.
module hslm_queue
  import hslm_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/hslm_back.sv
// Back end: clears, walks and averages the sector table, drives results.
module hslm_back
  import hslm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cmd_t          q_head,
  output logic          q_pop,
  hslm_out_if.source    out_chan
);

  back_state_t state_r, state_nxt;

  cmd_t                     cur_r, cur_nxt;
  logic [HEAD_W-1:0]        h_r, h_nxt;
  logic [SEC_W-1:0]         sec_r, sec_nxt;
  logic [SECTOR_COUNT-1:0]  valid_r, valid_nxt;
  logic [SEC_W-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;
  logic [MAG_W+21:0]        prod_r, prod_nxt;
  logic                     neg_r, neg_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [LIFT_W-1:0] out_data_r, out_data_nxt;

  // sector table, registered read
  logic signed [LIFT_W-1:0] mem [SECTOR_COUNT];
  logic signed [LIFT_W-1:0] rd_data_r;
  logic                     rd_ok_r;
  logic                     mem_we;
  logic                     rd_en;

  logic [HEAD_W:0]          diff_sum;
  logic [HEAD_W-1:0]        diff;
  logic                     diff_neg;
  logic [SUM_W-1:0]         acc_neg;
  logic [MAG_W-1:0]         mag;
  logic [LIFT_W-1:0]        quot;
  logic [LIFT_W-1:0]        quot_neg;
  logic signed [LIFT_W-1:0] rd_val;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.average_lift = out_data_r;

  always_comb begin
    // signed heading difference still to go, mod 3600
    diff_sum = {1'b0, cur_r.heading} + {1'b0, FULL_TURN} - {1'b0, h_r};
    if (diff_sum >= {1'b0, FULL_TURN}) begin
      diff = HEAD_W'(diff_sum - {1'b0, FULL_TURN});
    end else begin
      diff = diff_sum[HEAD_W-1:0];
    end
    diff_neg = diff > HALF_TURN;

    acc_neg  = -acc_r;
    mag      = acc_r[SUM_W-1] ? acc_neg[MAG_W-1:0] : acc_r[MAG_W-1:0];
    quot     = prod_r[RECIP_36_SHIFT +: LIFT_W];
    quot_neg = -quot;
    rd_val   = rd_ok_r ? rd_data_r : '0;

    state_nxt     = state_r;
    cur_nxt       = cur_r;
    h_nxt         = h_r;
    sec_nxt       = sec_r;
    valid_nxt     = valid_r;
    rd_cnt_nxt    = rd_cnt_r;
    rd_pend_nxt   = rd_pend_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head;
          h_nxt     = q_head.h_start;
          sec_nxt   = q_head.sec_start;
          state_nxt = q_head.clear ? ST_CLEAR : ST_WALK;
        end
      end
      ST_CLEAR: begin
        valid_nxt = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (cur_r.turning_left != diff_neg) begin
          rd_cnt_nxt  = '0;
          rd_pend_nxt = 1'b0;
          acc_nxt     = '0;
          state_nxt   = cur_r.north ? ST_SUM : ST_IDLE;
        end else begin
          mem_we           = 1'b1;
          valid_nxt[sec_r] = 1'b1;
          if (cur_r.turning_left) begin
            h_nxt   = (h_r >= SECTOR_WIDTH) ? h_r - SECTOR_WIDTH
                                            : h_r + (FULL_TURN - SECTOR_WIDTH);
            sec_nxt = (sec_r == '0) ? LAST_SECTOR : sec_r - 1'b1;
          end else begin
            h_nxt   = (h_r >= FULL_TURN - SECTOR_WIDTH) ? h_r - (FULL_TURN - SECTOR_WIDTH)
                                                        : h_r + SECTOR_WIDTH;
            sec_nxt = (sec_r == LAST_SECTOR) ? '0 : sec_r + 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (rd_cnt_r != SECTOR_TOTAL) begin
          rd_en      = 1'b1;
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        rd_pend_nxt = rd_en;
        if (rd_pend_r) begin
          acc_nxt = acc_r + SUM_W'(rd_val);
        end
        if (rd_cnt_r == SECTOR_TOTAL && !rd_pend_r) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        prod_nxt  = (MAG_W + 22)'(mag) * (MAG_W + 22)'(RECIP_36);
        neg_nxt   = acc_r[SUM_W-1];
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = neg_r ? quot_neg : quot;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    h_r        <= h_nxt;
    sec_r      <= sec_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[sec_r] <= cur_r.climb_rate;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_cnt_r];
      rd_ok_r   <= valid_r[rd_cnt_r];
    end
  end

endmodule

FILE: sv/heading_sector_lift_map_unit.sv
// Top level of the heading sector lift map: front end, command queue, back end.
//
// in_chan carries heading samples (heading, climb_rate, circling, turning_left);
// out_chan carries average_lift, one result per sample that crosses north.
// Both use valid/ready; a request is taken when valid and ready are high.
// The front end takes a request whenever the command queue has room
// (QUEUE_DEPTH entries), so ready only drops when the queue is full.
// The back end runs one command at a time: it takes the command, clears the
// table if asked, writes each sector it walks over (up to 19), then stops.
// A north crossing adds a pass that reads and sums the 36-entry sector memory,
// a multiply by the reciprocal of 36 and a load of the output register.
// When out_chan stalls, the result waits in the output register; the back end
// holds a further result until it drains, and the queue fills behind it.
// Reset zeroes the sector table through its valid bits, the stored heading
// and circling flag, and empties the queue; no clearing pass is needed.
module heading_sector_lift_map_unit
  import hslm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic       clk,
  input  logic       rst_n,
  hslm_in_if.sink    in_chan,
  hslm_out_if.source out_chan
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  hslm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  hslm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  hslm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (head_cmd),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for heading_sector_lift_map_unit with its own lift-map predictor.
module tb_top;
  import hslm_pkg::*;

  localparam int RANDOM_ITEMS  = 1950;
  localparam int TAIL_ITEMS    = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_ITEMS    = 24;
  localparam int DRAIN_CYCLES  = 80;
  localparam int TIMEOUT_TICKS = 20_000_000;

  // Tracks the sector table and queues the mean expected for each north crossing.
  class sector_lift_tracker;
    logic signed [LIFT_W-1:0] lift_tbl[SECTOR_COUNT];
    int unsigned              stored_heading;
    logic                     stored_circling;
    logic signed [LIFT_W-1:0] expected_means[$];
    int                       mismatches;
    int                       means_checked;
    int                       clears;
    int                       samples;

    function new();
      foreach (lift_tbl[i]) lift_tbl[i] = '0;
      stored_heading  = 0;
      stored_circling = 1'b0;
      mismatches      = 0;
      means_checked   = 0;
      clears          = 0;
      samples         = 0;
    endfunction

    function void take_sample(logic [HEAD_W-1:0] raw_heading, logic signed [LIFT_W-1:0] climb,
                              logic circ, logic left);
      int unsigned hd;
      int unsigned h;
      int unsigned d;
      int          steps;
      int          sum;
      hd = raw_heading;
      if (hd >= FULL_TURN) hd = hd - FULL_TURN;
      samples++;

      if (!circ && stored_circling) begin
        foreach (lift_tbl[i]) lift_tbl[i] = '0;
        clears++;
      end

      // walk 10-degree steps from the stored heading toward the new one
      h     = stored_heading;
      steps = 0;
      d     = (hd + FULL_TURN - h) % FULL_TURN;
      while ((left == (d > HALF_TURN)) && steps < 40) begin
        lift_tbl[((h + HALF_SECTOR) % FULL_TURN) / SECTOR_WIDTH] = climb;
        if (left) h = (h + FULL_TURN - SECTOR_WIDTH) % FULL_TURN;
        else      h = (h + SECTOR_WIDTH) % FULL_TURN;
        d = (hd + FULL_TURN - h) % FULL_TURN;
        steps++;
      end

      if ((hd < QUARTER_TURN && stored_heading > THREE_QUARTER_TURN) ||
          (stored_heading < QUARTER_TURN && hd > THREE_QUARTER_TURN)) begin
        sum = 0;
        foreach (lift_tbl[i]) sum += lift_tbl[i];
        expected_means = {expected_means, LIFT_W'(sum / SECTOR_COUNT)};
      end

      stored_circling = circ;
      stored_heading  = hd;
    endfunction

    function void check_mean(logic signed [LIFT_W-1:0] actual);
      logic signed [LIFT_W-1:0] want;
      if (expected_means.size() == 0) begin
        $error("average_lift unexpected result, expected none actual %0d", actual);
        mismatches++;
      end else begin
        want = expected_means[0];
        expected_means.delete(0);
        means_checked++;
        if (actual !== want) begin
          $error("average_lift expected %0d actual %0d", want, actual);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_means.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic stall_ok;
  logic hold_req;
  logic hold_done;

  hslm_in_if  in_if();
  hslm_out_if out_if();

  sector_lift_tracker tracker;

  heading_sector_lift_map_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #(TIMEOUT_TICKS);
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_if.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_ok && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) tracker.check_mean(out_if.average_lift);
  end

  task automatic send_sample(input logic [HEAD_W-1:0] hd, input logic signed [LIFT_W-1:0] climb,
                             input logic circ, input logic left, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.heading      <= hd;
    in_if.climb_rate   <= climb;
    in_if.circling     <= circ;
    in_if.turning_left <= left;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.take_sample(hd, climb, circ, left);
  endtask

  function automatic int pick_gap(bit calm);
    if (calm || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 10);
  endfunction

  initial begin
    int          n;
    int          k;
    int          seg_len;
    int          step;
    int          directed;
    int unsigned cur;
    logic        dir;
    logic        circ;
    logic        wide;
    bit          calm;
    logic [HEAD_W-1:0]        hd;
    logic signed [LIFT_W-1:0] climb;

    tracker            = new();
    rst_n              = 1'b0;
    stall_ok           = 1'b1;
    hold_req           = 1'b0;
    in_if.valid        = 1'b0;
    in_if.heading      = '0;
    in_if.climb_rate   = '0;
    in_if.circling     = 1'b0;
    in_if.turning_left = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: same heading both ways, half turn, longest walks, wraps, clears, bands
    send_sample(12'd0,    16'sd32767,  1'b1, 1'b0, 0);
    send_sample(12'd0,    16'sd100,    1'b1, 1'b1, 0);
    send_sample(12'd1800, -16'sd32768, 1'b1, 1'b0, pick_gap(0));
    send_sample(12'd3599, 16'sd5,      1'b1, 1'b0, 0);
    send_sample(12'd0,    -16'sd7,     1'b1, 1'b0, pick_gap(0));
    send_sample(12'd1801, 16'sd32767,  1'b1, 1'b1, 0);
    send_sample(12'd1801, 16'sd1,      1'b0, 1'b0, 0);
    send_sample(12'd4095, -16'sd1,     1'b0, 1'b0, pick_gap(0));
    send_sample(12'd3600, 16'sd12345,  1'b1, 1'b1, 0);
    send_sample(12'd2701, -16'sd32768, 1'b1, 1'b1, 0);
    send_sample(12'd899,  16'sd32767,  1'b1, 1'b0, pick_gap(0));
    send_sample(12'd2700, 16'sd0,      1'b1, 1'b0, 0);
    send_sample(12'd900,  16'sd0,      1'b1, 1'b0, 0);
    send_sample(12'd0,    16'sd32767,  1'b0, 1'b0, 0);
    // whole table at the positive extreme and a crossing, then 19 sectors at the negative extreme and a crossing
    send_sample(12'd1800, 16'sd32767,  1'b1, 1'b0, 0);
    send_sample(12'd0,    16'sd32767,  1'b1, 1'b0, 0);
    send_sample(12'd3599, 16'sd32767,  1'b1, 1'b0, 0);
    send_sample(12'd1800, -16'sd32768, 1'b1, 1'b0, 0);
    send_sample(12'd0,    -16'sd32768, 1'b1, 1'b0, 0);
    send_sample(12'd3599, -16'sd32768, 1'b1, 1'b1, 0);
    directed = tracker.samples;

    // output held off while every request crosses north, so the queue backs up
    hold_req = 1'b1;
    for (k = 0; k < HOLD_ITEMS; k++) begin
      hd = k[0] ? 12'd3500 : 12'd100;
      send_sample(hd, 16'($urandom), 1'b1, k[1], 0);
    end

    cur = 0;
    n   = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        calm     = (n >= RANDOM_ITEMS - TAIL_ITEMS);
        stall_ok = !calm;
        send_sample(12'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), pick_gap(calm));
        n++;
      end else begin
        seg_len  = $urandom_range(4, 40);
        dir      = 1'($urandom);
        wide     = ($urandom_range(0, 3) == 0);
        calm     = ($urandom_range(0, 3) == 0);
        for (k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
          if (n >= RANDOM_ITEMS - TAIL_ITEMS) calm = 1'b1;
          stall_ok = !calm;
          step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1900) : $urandom_range(0, 450);
          cur  = dir ? (cur + FULL_TURN - step) % FULL_TURN : (cur + step) % FULL_TURN;
          hd   = HEAD_W'(cur);
          if (cur < 496 && $urandom_range(0, 9) == 0) hd = HEAD_W'(cur + FULL_TURN);
          circ  = ($urandom_range(0, 11) != 0);
          climb = wide ? 16'($urandom) : 16'(int'($urandom_range(0, 1000)) - 500);
          send_sample(hd, climb, circ, dir, pick_gap(calm));
          n++;
        end
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d heading samples (%0d directed), %0d north-crossing means checked",
             tracker.samples, directed, tracker.means_checked);
    $display("%0d table clears on leaving a circle, one %0d-cycle output hold-off",
             tracker.clears, HOLD_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
